// ----- design/lz_token_stream_decompressor_top_defines.svh -----
// assertion macros for the lz token stream decompressor
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef LZ_TOKEN_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZ_TOKEN_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH

// property must hold at every rising clock edge outside reset
`define LZD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define LZD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- design/lzd_pkg.sv -----
// shared constants, types and helpers of the lz token stream decompressor
// no dependencies
package lzd_pkg;

  // history window
  localparam int unsigned WINDOW_DEPTH = 8192;
  localparam int unsigned WIN_AW       = $clog2(WINDOW_DEPTH);

  // stream format
  localparam int unsigned REM_W     = 24;
  localparam int unsigned DIST_W    = 12;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned MIN_MATCH = 3;
  localparam int unsigned FLAG_CNT  = 8;

  // command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // output queue of the back end
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // one decoded token handed to the back end
  typedef struct packed {
    logic              is_match;
    logic [7:0]        lit;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  len;
    logic              ovr;
    logic              last;
  } cmd_t;

  // one output byte waiting to leave
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovr;
  } out_item_t;

  // back end status seen by the top level
  typedef struct packed {
    logic [OUTQ_CW-1:0] out_count;
    logic               busy;
    logic [LEN_W-1:0]   left;
  } bk_status_t;

  // next window position with wrap
  function automatic logic [WIN_AW-1:0] win_inc(input logic [WIN_AW-1:0] a);
    logic [WIN_AW-1:0] r;
    if (a == WIN_AW'(WINDOW_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = a + 1'b1;
    end
    return r;
  endfunction

  // window position distance+3 bytes behind pos, with wrap
  function automatic logic [WIN_AW-1:0] win_back(input logic [WIN_AW-1:0] pos,
                                                  input logic [DIST_W-1:0] distance);
    logic [WIN_AW:0] d3;
    logic [WIN_AW:0] p;
    d3 = (WIN_AW+1)'(distance) + (WIN_AW+1)'(MIN_MATCH);
    p  = {1'b0, pos};
    if (p < d3) begin
      p = p + (WIN_AW+1)'(WINDOW_DEPTH) - d3;
    end else begin
      p = p - d3;
    end
    return p[WIN_AW-1:0];
  endfunction

endpackage

// ----- design/lzd_stream_if.sv -----
// valid/ready channel interfaces for compressed input and decoded output
// no dependencies
interface lzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

interface lzd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       overrun;

  modport source (output valid, output data_byte, output last_byte, output overrun,
                  input ready);
  modport sink   (input valid, input data_byte, input last_byte, input overrun,
                  output ready);
endinterface

// ----- design/lzd_front.sv -----
// front end: parses header, flag bytes and tokens, emits literal/match commands
// depends on lzd_pkg and lzd_in_if
module lzd_front import lzd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      mode_i,
  lzd_in_if.sink    in_i,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i,
  output cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_FLAG, PH_LIT, PH_MHI, PH_MLO
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [7:0]       flag_q, flag_d;
  logic [3:0]       left_q, left_d;
  logic [7:0]       mhb_q, mhb_d;

  // values after a possible restart
  phase_e           phase_v;
  logic [REM_W-1:0] rem_v;
  logic [7:0]       flag_v;
  logic [3:0]       left_v;

  logic [REM_W-1:0] hdr_rem;
  logic [REM_W-1:0] rem_after;
  logic [LEN_W-1:0] len_full;
  logic [LEN_W-1:0] len_cut;
  logic             cut;
  logic             is_item;
  logic             push;
  logic [7:0]       b;
  logic             accept;

  assign b          = in_i.in_byte;
  assign in_i.ready = cmd_ready_i;
  assign accept     = in_i.valid && cmd_ready_i;

  // parse one item
  always_comb begin
    phase_v = phase_q;
    rem_v   = rem_q;
    flag_v  = flag_q;
    left_v  = left_q;
    mhb_d   = mhb_q;
    if (in_i.stream_start) begin
      phase_v = PH_HDR0;
      rem_v   = '0;
      flag_v  = '0;
      left_v  = '0;
      mhb_d   = '0;
    end

    phase_d   = phase_v;
    rem_d     = rem_v;
    flag_d    = flag_v;
    left_d    = left_v;
    hdr_rem   = {rem_v[REM_W-9:0], b};
    len_full  = LEN_W'(b[3:0]) + LEN_W'(MIN_MATCH);
    cut       = REM_W'(len_full) > rem_v;
    len_cut   = cut ? rem_v[LEN_W-1:0] : len_full;
    rem_after = rem_v;
    is_item   = 1'b0;
    push      = 1'b0;
    cmd_o     = '0;

    unique case (phase_v)
      PH_HDR1: begin
        rem_d = hdr_rem;
        if (mode_i) begin
          phase_d = PH_HDR2;
        end else begin
          flag_d  = '0;
          left_d  = '0;
          phase_d = (hdr_rem == '0) ? PH_HDR0 : PH_FLAG;
        end
      end
      PH_HDR2: begin
        rem_d   = hdr_rem;
        flag_d  = '0;
        left_d  = '0;
        phase_d = (hdr_rem == '0) ? PH_HDR0 : PH_FLAG;
      end
      PH_FLAG: begin
        flag_d  = b;
        left_d  = 4'(FLAG_CNT);
        phase_d = b[7] ? PH_MHI : PH_LIT;
      end
      PH_LIT: begin
        rem_after    = rem_v - 1'b1;
        is_item      = 1'b1;
        push         = 1'b1;
        cmd_o.lit    = b;
        cmd_o.last   = (rem_after == '0);
      end
      PH_MHI: begin
        mhb_d   = b;
        phase_d = PH_MLO;
      end
      PH_MLO: begin
        rem_after      = rem_v - REM_W'(len_cut);
        is_item        = 1'b1;
        push           = 1'b1;
        cmd_o.is_match = 1'b1;
        cmd_o.distance = {mhb_q, b[7:4]};
        cmd_o.len      = len_cut;
        cmd_o.ovr      = cut;
        cmd_o.last     = (rem_after == '0);
      end
      default: begin
        rem_d   = REM_W'(b);
        flag_d  = '0;
        left_d  = '0;
        phase_d = PH_HDR1;
      end
    endcase

    // move to the next flag or end the stream
    if (is_item) begin
      rem_d = rem_after;
      if (rem_after == '0) begin
        phase_d = PH_HDR0;
      end else begin
        flag_d = {flag_v[6:0], 1'b0};
        left_d = left_v - 4'd1;
        if (left_d == '0) begin
          phase_d = PH_FLAG;
        end else begin
          phase_d = flag_d[7] ? PH_MHI : PH_LIT;
        end
      end
    end
  end

  assign cmd_valid_o = in_i.valid && push;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      rem_q   <= '0;
      flag_q  <= '0;
      left_q  <= '0;
      mhb_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      flag_q  <= flag_d;
      left_q  <= left_d;
      mhb_q   <= mhb_d;
    end
  end

endmodule

// ----- design/lzd_cmd_fifo.sv -----
// short command queue between front and back end
// depends on lzd_pkg
module lzd_cmd_fifo import lzd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  cmd_t               push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output cmd_t               pop_data_o,
  output logic [CMDQ_CW-1:0] count_o
);

  cmd_t               slot_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_CW-1:0] cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CMDQ_CW'(CMDQ_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign count_o      = cnt_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/lzd_back.sv -----
// back end: runs literal and match commands against the history window
// depends on lzd_pkg and lzd_out_if
module lzd_back import lzd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  lzd_out_if.source  out_o,
  output bk_status_t status_o
);

  // history window, one write and one read port
  logic [7:0]        hist_mem [WINDOW_DEPTH];
  logic [7:0]        rdata_q;
  logic [7:0]        wdata;

  // match sequencer
  logic [WIN_AW-1:0] pos_q, src_q;
  logic              wrapped_q;
  logic              busy_q;
  logic [LEN_W-1:0]  left_q;
  logic              mlast_q, movr_q;

  // read stage
  logic              s1_valid_q;
  logic              s1_match_q, s1_zero_q, s1_last_q, s1_ovr_q;
  logic [7:0]        s1_lit_q;
  logic [WIN_AW-1:0] s1_addr_q;

  // output queue
  out_item_t         outq_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUTQ_CW-1:0] cnt_q;

  logic can_issue, cmd_take, step, lit_issue, issue, pop;

  // room for everything already in flight plus one more byte
  assign can_issue   = ((OUTQ_CW+1)'(cnt_q) + (OUTQ_CW+1)'(s1_valid_q))
                       < (OUTQ_CW+1)'(OUTQ_DEPTH);
  assign cmd_ready_o = !busy_q && can_issue;
  assign cmd_take    = cmd_valid_i && cmd_ready_o;
  assign step        = busy_q && can_issue;
  assign lit_issue   = cmd_take && !cmd_i.is_match;
  assign issue       = step || lit_issue;

  // unwritten window entries read as zero
  assign wdata = s1_match_q ? (s1_zero_q ? 8'h00 : rdata_q) : s1_lit_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      hist_mem[s1_addr_q] <= wdata;
    end
    rdata_q <= hist_mem[src_q];
  end

  // sequencer and fill mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      src_q      <= '0;
      wrapped_q  <= 1'b0;
      busy_q     <= 1'b0;
      left_q     <= '0;
      mlast_q    <= 1'b0;
      movr_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cmd_take && cmd_i.is_match) begin
        busy_q  <= 1'b1;
        src_q   <= win_back(pos_q, cmd_i.distance);
        left_q  <= cmd_i.len;
        mlast_q <= cmd_i.last;
        movr_q  <= cmd_i.ovr;
      end else if (step) begin
        src_q  <= win_inc(src_q);
        left_q <= left_q - 1'b1;
        if (left_q == LEN_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
      if (issue) begin
        pos_q <= win_inc(pos_q);
        if (pos_q == WIN_AW'(WINDOW_DEPTH - 1)) begin
          wrapped_q <= 1'b1;
        end
      end
      s1_valid_q <= issue;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_match_q <= 1'b1;
      s1_zero_q  <= !wrapped_q && (src_q >= pos_q);
      s1_lit_q   <= '0;
      s1_addr_q  <= pos_q;
      s1_last_q  <= mlast_q && (left_q == LEN_W'(1));
      s1_ovr_q   <= movr_q;
    end else if (lit_issue) begin
      s1_match_q <= 1'b0;
      s1_zero_q  <= 1'b0;
      s1_lit_q   <= cmd_i.lit;
      s1_addr_q  <= pos_q;
      s1_last_q  <= cmd_i.last;
      s1_ovr_q   <= 1'b0;
    end
  end

  // output queue
  assign out_o.valid     = (cnt_q != '0);
  assign out_o.data_byte = outq_q[rd_ptr_q].data;
  assign out_o.last_byte = outq_q[rd_ptr_q].last;
  assign out_o.overrun   = outq_q[rd_ptr_q].ovr;
  assign pop             = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s1_valid_q) begin
        wr_ptr_q <= (wr_ptr_q == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (s1_valid_q && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !s1_valid_q) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      outq_q[wr_ptr_q] <= '{data: wdata, last: s1_last_q, ovr: s1_ovr_q};
    end
  end

  assign status_o = '{out_count: cnt_q, busy: busy_q, left: left_q};

endmodule

// ----- design/lz_token_stream_decompressor_top.sv -----
// top level of the lz token stream decompressor
// depends on lzd_pkg, lzd_stream_if, lzd_front, lzd_cmd_fifo, lzd_back and the defines header
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   in_byte[7:0], stream_start
//   out_o    out  valid/ready   data_byte[7:0], last_byte, overrun
//   cfg      in   cfg_we_i      cfg_wdata_i (size_header_mode)
//
// an input byte is taken whenever the 4-entry command queue has room.
// the back end issues a literal as it takes the command; a match is taken first and
// then copies its bytes (up to 18) one at a time, bound by the single read port of the history memory.
// output bytes leave at one per cycle while the receiver is ready, through a 4-entry queue.
// reset clears control only; the window uses a fill mark instead of a clearing pass.
// either side may stall at any time; the queues absorb it.
`include "lz_token_stream_decompressor_top_defines.svh"

module lz_token_stream_decompressor_top import lzd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lzd_in_if.sink     in_i,
  lzd_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  logic               mode_q;
  logic               fr_valid, fr_ready;
  cmd_t               fr_cmd;
  logic               bk_valid, bk_ready;
  cmd_t               bk_cmd;
  logic [CMDQ_CW-1:0] cmdq_count;
  bk_status_t         bk_status;

  // size header mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  lzd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_i        (in_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  lzd_cmd_fifo u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_cmd),
    .count_o      (cmdq_count)
  );

  lzd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cmd_i       (bk_cmd),
    .out_o       (out_o),
    .status_o    (bk_status)
  );

  // checks on queue credit and match sequencing
  `LZD_ASSERT(a_outq_bound, bk_status.out_count <= OUTQ_CW'(OUTQ_DEPTH), "output queue overfilled")
  `LZD_ASSERT(a_cmdq_bound, cmdq_count <= CMDQ_CW'(CMDQ_DEPTH), "command queue overfilled")
  `LZD_ASSERT_NEVER(a_busy_left, bk_status.busy && (bk_status.left == '0), "empty match busy")

endmodule

// ----- test/lzd_tb_pkg.sv -----
// scoreboard for the lz token stream decompressor testbench
// depends on lzd_pkg for window size, field widths and the output item type
`timescale 1ns / 1ps

package lzd_tb_pkg;
  import lzd_pkg::*;

  // parser phases of the stream decoder
  typedef enum logic [2:0] {
    SP_HDR0,
    SP_HDR1,
    SP_HDR2,
    SP_FLAG,
    SP_LIT,
    SP_MHI,
    SP_MLO
  } stream_phase_e;

  class decode_scoreboard;
    logic              hdr24;
    stream_phase_e     phase;
    logic [REM_W-1:0]  left_count;
    logic [7:0]        flags;
    logic [3:0]        flags_to_go;
    logic [7:0]        dist_hi;
    logic [7:0]        window [WINDOW_DEPTH];
    logic [WIN_AW-1:0] wr_pos;
    out_item_t         pending_bytes [$];
    int unsigned       errors;
    int unsigned       inputs_seen;
    int unsigned       checked;
    int unsigned       cut_bytes;

    function new();
      hdr24       = 1'b0;
      wr_pos      = '0;
      errors      = 0;
      inputs_seen = 0;
      checked     = 0;
      cut_bytes   = 0;
      clear_parser();
      foreach (window[i]) window[i] = 8'h00;
    endfunction

    function void clear_parser();
      phase       = SP_HDR0;
      left_count  = '0;
      flags       = 8'h00;
      flags_to_go = 4'd0;
      dist_hi     = 8'h00;
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction

    // one decoded byte into the window and onto the expected list
    // the window depth is a power of two, so the position wraps by width
    function void push_byte(logic [7:0] b, logic ovr);
      out_item_t e;
      window[wr_pos] = b;
      wr_pos         = wr_pos + 1'b1;
      left_count     = left_count - 1'b1;
      e.data         = b;
      e.last         = (left_count == '0);
      e.ovr          = ovr;
      pending_bytes.push_back(e);
    endfunction

    // end of stream or advance to the next flag bit
    function void end_item();
      if (left_count == '0) begin
        phase = SP_HDR0;
        return;
      end
      flags       = flags << 1;
      flags_to_go = flags_to_go - 1'b1;
      if (flags_to_go == 4'd0) begin
        phase = SP_FLAG;
      end else begin
        phase = flags[7] ? SP_MHI : SP_LIT;
      end
    endfunction

    function void header_done();
      flags_to_go = 4'd0;
      flags       = 8'h00;
      phase       = (left_count == '0) ? SP_HDR0 : SP_FLAG;
    endfunction

    // accepted input item: work out the bytes it produces
    function void take_input(logic [7:0] b, logic start);
      logic [11:0]       distance;
      logic [4:0]        len;
      logic              ovr;
      logic [WIN_AW-1:0] src;
      inputs_seen++;
      if (start) clear_parser();
      case (phase)
        SP_HDR1: begin
          left_count = {left_count[15:0], b};
          if (hdr24) begin
            phase = SP_HDR2;
          end else begin
            header_done();
          end
        end
        SP_HDR2: begin
          left_count = {left_count[15:0], b};
          header_done();
        end
        SP_FLAG: begin
          flags       = b;
          flags_to_go = 4'(FLAG_CNT);
          phase       = b[7] ? SP_MHI : SP_LIT;
        end
        SP_LIT: begin
          push_byte(b, 1'b0);
          end_item();
        end
        SP_MHI: begin
          dist_hi = b;
          phase   = SP_MLO;
        end
        SP_MLO: begin
          distance = {dist_hi, b[7:4]};
          len      = 5'(b[3:0]) + 5'(MIN_MATCH);
          ovr      = 1'b0;
          // match running past the declared size is cut
          if (REM_W'(len) > left_count) begin
            len = left_count[4:0];
            ovr = 1'b1;
          end
          src = wr_pos - WIN_AW'(distance) - WIN_AW'(MIN_MATCH);
          for (int i = 0; i < int'(len); i++) begin
            push_byte(window[src], ovr);
            src = src + 1'b1;
          end
          end_item();
        end
        default: begin
          left_count  = REM_W'(b);
          flags       = 8'h00;
          flags_to_go = 4'd0;
          phase       = SP_HDR1;
        end
      endcase
    endfunction

    // accepted output item against the oldest expected byte
    function void check_byte(logic [7:0] data, logic last, logic ovr);
      out_item_t e;
      if (pending_bytes.size() == 0) begin
        $error("unexpected output byte %02h (last %0b, overrun %0b)", data, last, ovr);
        errors++;
        return;
      end
      e = pending_bytes.pop_front();
      checked++;
      if (e.ovr) cut_bytes++;
      if (data !== e.data) begin
        $error("data_byte mismatch: expected %02h, actual %02h", e.data, data);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_byte mismatch: expected %0b, actual %0b", e.last, last);
        errors++;
      end
      if (ovr !== e.ovr) begin
        $error("overrun mismatch: expected %0b, actual %0b", e.ovr, ovr);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- test/tb.sv -----
// top of the lz token stream decompressor testbench: clock, reset, drivers
// depends on lzd_pkg, lzd_stream_if, lzd_tb_pkg and the top level
`timescale 1ns / 1ps

module tb;
  import lzd_pkg::*;
  import lzd_tb_pkg::*;

  localparam int unsigned IDLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_ITEMS = 45;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  lzd_in_if  in_if ();
  lzd_out_if out_if ();

  lz_token_stream_decompressor_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  decode_scoreboard sb = new();

  int unsigned items_sent   = 0;
  int unsigned cycles       = 0;
  bit          quiet_phase  = 1'b0;
  bit          calm         = 1'b0;
  bit          rx_hold_req  = 1'b0;
  bit          stream_clean = 1'b1;
  logic        cur_mode     = 1'b0;

  always #6 clk_i = ~clk_i;

  // watch both channels; outputs first, as they never come from this edge's input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_byte(out_if.data_byte, out_if.last_byte, out_if.overrun);
      end
      if (in_if.valid && in_if.ready) begin
        sb.take_input(in_if.in_byte, in_if.stream_start);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycles, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    forever begin
      if (rx_hold_req && !quiet_phase) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (quiet_phase || $urandom_range(0, 3) != 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  // offer one item, with an occasional gap before it
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (!quiet_phase && !calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.in_byte      <= b;
    in_if.stream_start <= start;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  // wait for every expected byte, then let the block settle
  task automatic wait_for_output_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_header_mode(input logic m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_mode  = m;
    sb.hdr24  = m;
  endtask

  // header, then flag groups with random literals and matches;
  // a non-zero cut abandons the stream after that many items past the header
  task automatic send_stream(input logic [23:0] size, input logic start,
                             input int unsigned cut);
    int unsigned left;
    int unsigned budget;
    logic [7:0]  fl;
    logic [11:0] d;
    logic [3:0]  l;
    if (cur_mode) begin
      left = 32'(size);
      send_byte(size[23:16], start);
      send_byte(size[15:8], 1'b0);
    end else begin
      left = 32'(size[15:0]);
      send_byte(size[15:8], start);
    end
    send_byte(size[7:0], 1'b0);
    budget = (cut == 0) ? 32'hFFFF_FFFF : cut;
    while (left != 0 && budget != 0) begin
      fl = 8'($urandom_range(0, 255));
      send_byte(fl, 1'b0);
      budget--;
      for (int k = 7; k >= 0 && left != 0 && budget != 0; k--) begin
        if (fl[k]) begin
          // mostly near references, some far back into old or cleared history
          case ($urandom_range(0, 5))
            0:       d = 12'($urandom_range(0, 4095));
            1:       d = 12'hFFF;
            default: d = 12'($urandom_range(0, 12));
          endcase
          l = 4'($urandom_range(0, 15));
          send_byte(d[11:4], 1'b0);
          budget--;
          if (budget != 0) begin
            send_byte({d[3:0], l}, 1'b0);
            budget--;
            left = (int'(l) + 3 >= left) ? 0 : left - (int'(l) + 3);
          end
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'b0);
          budget--;
          left--;
        end
      end
    end
    stream_clean = (left == 0);
  endtask

  initial begin
    int unsigned target;
    int unsigned pick;
    int unsigned cut;
    logic [23:0] sz;
    logic        st;
    bit          paused;
    in_if.valid        <= 1'b0;
    in_if.in_byte      <= 8'h00;
    in_if.stream_start <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 1'b0;
    rst_ni             <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_header_mode(1'b0);

    // zero size stream
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    // size 7 opened without a start mark: extreme literals, shortest match,
    // then a longest far-back match cut by the size, leaving flags unused
    send_byte(8'h00, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // largest 16-bit size, abandoned by a restart
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    wait_for_output_drain();

    // 24-bit header: size 3 with a cut match, then zero size
    set_header_mode(1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    stream_clean = 1'b1;

    // random phases alternating the header mode, the last one without idling
    paused = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      wait_for_output_drain();
      set_header_mode(ph[0]);
      quiet_phase = (ph == 3);
      calm        = 1'b0;
      target      = items_sent + PHASE_ITEMS;
      if (ph == 0) begin
        // long receiver hold-off while a long stream keeps coming
        rx_hold_req = 1'b1;
        send_stream(24'd80, 1'b1, 0);
      end
      while (items_sent < target) begin
        calm = ($urandom_range(0, 3) == 0);
        st   = !(stream_clean && $urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          // noise with occasional restarts
          repeat ($urandom_range(1, 6)) begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 5) == 0));
          end
          stream_clean = 1'b0;
        end else if (pick == 1) begin
          sz = 24'($urandom_range(0, 32'hFF_FFFF));
          send_stream(sz, 1'b1, $urandom_range(1, 12));
        end else if (pick == 2) begin
          send_stream(24'($urandom_range(10, 40)), 1'b1, $urandom_range(1, 10));
        end else begin
          case ($urandom_range(0, 19))
            0:       sz = 24'd0;
            1:       sz = 24'($urandom_range(40, 100));
            2:       sz = 24'($urandom_range(256, 300));
            default: sz = 24'($urandom_range(1, 24));
          endcase
          cut = 0;
          send_stream(sz, st, cut);
        end
        // sender pause until every byte is out
        if (ph == 2 && !paused && items_sent + 25 >= target) begin
          wait_for_output_drain();
          paused = 1'b1;
        end
      end
    end

    wait_for_output_drain();
    $display("%0d input items, %0d output bytes checked, %0d of them from cut matches,",
             sb.inputs_seen, sb.checked, sb.cut_bytes);
    $display("over 16- and 24-bit headers with restarts, noise and receiver hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/lzd_pkg.sv
design/lzd_stream_if.sv
design/lzd_front.sv
design/lzd_cmd_fifo.sv
design/lzd_back.sv
design/lz_token_stream_decompressor_top.sv
test/lzd_tb_pkg.sv
test/tb.sv
